/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold at the edge where ante holds
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold at the edge after the one where ante holds
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bru_pkg.sv */
package bru_pkg;

  localparam int SRC_WIDTH_DEF   = 320;
  localparam int SRC_HEIGHT_DEF  = 240;
  localparam int MAX_OUT_DIM_DEF = 4096;

  localparam int POS_W      = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_ADDR_W = 4;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 24;
  localparam int FRAC_W     = 8;
  localparam int QDEPTH     = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_OUT_WIDTH  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_HEIGHT = 4'd1;

  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd480;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_REQ  = 2'd2
  } kind_t;

  // x/y: source index (fx/fy valid on requests), rgb valid on loads
  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  x;
    logic [FRAC_W-1:0] fx;
    logic [POS_W-1:0]  y;
    logic [FRAC_W-1:0] fy;
    logic [RGB_W-1:0]  rgb;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

/* hdl/bru_front.sv */
module bru_front #(
  parameter int SRC_WIDTH   = bru_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT  = bru_pkg::SRC_HEIGHT_DEF,
  parameter int MAX_OUT_DIM = bru_pkg::MAX_OUT_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_take,
  input  logic                           in_cmd,
  input  logic [bru_pkg::POS_W-1:0]      in_x,
  input  logic [bru_pkg::POS_W-1:0]      in_y,
  input  logic [bru_pkg::RGB_W-1:0]      in_rgb,
  input  logic [bru_pkg::CFG_W-1:0]      out_width,
  input  logic [bru_pkg::CFG_W-1:0]      out_height,
  output logic                           push,
  output bru_pkg::item_t                 push_item
);

  localparam int PW  = bru_pkg::POS_W;
  localparam int DW  = bru_pkg::CFG_W;
  localparam int FW  = bru_pkg::FRAC_W;
  localparam int XW  = $clog2(SRC_WIDTH);
  localparam int YW  = $clog2(SRC_HEIGHT);
  localparam int IW  = (XW > YW) ? XW : YW;
  localparam int QW  = IW + FW;
  localparam int NW  = PW + QW;
  localparam int MW  = NW - FW;
  localparam int CAP = (MAX_OUT_DIM < (1 << DW) - 1) ? MAX_OUT_DIM : (1 << DW) - 1;

  localparam logic [DW-1:0] DIM_CAP = DW'(CAP);
  localparam logic [DW-1:0] ONE     = DW'(1);
  localparam logic [MW-1:0] SRC_XM1 = MW'(SRC_WIDTH - 1);
  localparam logic [MW-1:0] SRC_YM1 = MW'(SRC_HEIGHT - 1);
  localparam logic [PW:0]   SRC_W_C = (PW + 1)'(SRC_WIDTH);
  localparam logic [PW:0]   SRC_H_C = (PW + 1)'(SRC_HEIGHT);
  localparam logic [IW-1:0] X_MAX   = IW'(SRC_WIDTH - 1);
  localparam logic [IW-1:0] Y_MAX   = IW'(SRC_HEIGHT - 1);

  function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] rem,
                                               input logic [QW-1:0] wq,
                                               input logic [DW-1:0] dv);
    logic [DW:0] r2;
    logic        ge;
    logic [DW:0] d;
    r2 = {rem, wq[QW-1]};
    ge = r2 >= {1'b0, dv};
    d  = ge ? r2 - {1'b0, dv} : r2;
    return {d[DW-1:0], wq[QW-2:0], ge};
  endfunction

  logic [DW-1:0] dim_x, dim_y, div_x, div_y, lim_x, lim_y;
  logic [PW-1:0] pc_x, pc_y;
  logic [NW-1:0] num_x, num_y;
  bru_pkg::kind_t in_kind;

  always_comb begin
    dim_x = out_width;
    if (out_width == '0) dim_x = ONE;
    else if (out_width > DIM_CAP) dim_x = DIM_CAP;
    dim_y = out_height;
    if (out_height == '0) dim_y = ONE;
    else if (out_height > DIM_CAP) dim_y = DIM_CAP;
    lim_x = dim_x - ONE;
    lim_y = dim_y - ONE;
    div_x = (dim_x > ONE) ? lim_x : ONE;
    div_y = (dim_y > ONE) ? lim_y : ONE;
    // clamp requests past the output edge to the last column / row
    pc_x = ({1'b0, in_x} >= dim_x) ? lim_x[PW-1:0] : in_x;
    pc_y = ({1'b0, in_y} >= dim_y) ? lim_y[PW-1:0] : in_y;
    num_x = {MW'(pc_x) * SRC_XM1, {FW{1'b0}}};
    num_y = {MW'(pc_y) * SRC_YM1, {FW{1'b0}}};
    if (in_cmd == bru_pkg::CMD_REQUEST) in_kind = bru_pkg::KIND_REQ;
    else if ({1'b0, in_x} < SRC_W_C && {1'b0, in_y} < SRC_H_C) in_kind = bru_pkg::KIND_LOAD;
    else in_kind = bru_pkg::KIND_SKIP;
  end

  logic           st_v    [QW+1];
  bru_pkg::kind_t st_kind [QW+1];
  logic [DW-1:0]  st_rx   [QW+1];
  logic [DW-1:0]  st_ry   [QW+1];
  logic [QW-1:0]  st_wx   [QW+1];
  logic [QW-1:0]  st_wy   [QW+1];
  logic [PW-1:0]  st_lx   [QW+1];
  logic [PW-1:0]  st_ly   [QW+1];
  logic [bru_pkg::RGB_W-1:0] st_rgb [QW+1];

  logic [DW+QW-1:0] step_x [QW];
  logic [DW+QW-1:0] step_y [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      step_x[k] = div_step(st_rx[k], st_wx[k], div_x);
      step_y[k] = div_step(st_ry[k], st_wy[k], div_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) st_v[k] <= 1'b0;
    end else begin
      st_v[0] <= in_take;
      for (int k = 0; k < QW; k++) st_v[k+1] <= st_v[k];
    end
    // remainder starts below the divisor since the quotient fits in QW bits
    st_kind[0] <= in_kind;
    st_rx[0]   <= {1'b0, num_x[NW-1:QW]};
    st_ry[0]   <= {1'b0, num_y[NW-1:QW]};
    st_wx[0]   <= num_x[QW-1:0];
    st_wy[0]   <= num_y[QW-1:0];
    st_lx[0]   <= in_x;
    st_ly[0]   <= in_y;
    st_rgb[0]  <= in_rgb;
    for (int k = 0; k < QW; k++) begin
      st_kind[k+1] <= st_kind[k];
      st_rx[k+1]   <= step_x[k][DW+QW-1:QW];
      st_ry[k+1]   <= step_y[k][DW+QW-1:QW];
      st_wx[k+1]   <= step_x[k][QW-1:0];
      st_wy[k+1]   <= step_y[k][QW-1:0];
      st_lx[k+1]   <= st_lx[k];
      st_ly[k+1]   <= st_ly[k];
      st_rgb[k+1]  <= st_rgb[k];
    end
  end

  logic [IW-1:0] xi, yi;

  always_comb begin
    xi = st_wx[QW][QW-1:FW];
    yi = st_wy[QW][QW-1:FW];
    if (xi > X_MAX) xi = X_MAX;
    if (yi > Y_MAX) yi = Y_MAX;
    push_item.kind = st_kind[QW];
    push_item.rgb  = st_rgb[QW];
    if (st_kind[QW] == bru_pkg::KIND_REQ) begin
      push_item.x  = PW'(xi);
      push_item.y  = PW'(yi);
      push_item.fx = st_wx[QW][FW-1:0];
      push_item.fy = st_wy[QW][FW-1:0];
    end else begin
      push_item.x  = st_lx[QW];
      push_item.y  = st_ly[QW];
      push_item.fx = '0;
      push_item.fy = '0;
    end
  end

  assign push = st_v[QW];

endmodule

/* hdl/bru_fifo.sv */
`include "assert_macros.svh"

module bru_fifo #(
  parameter int DEPTH = bru_pkg::QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bru_pkg::item_t     push_item,
  input  logic               pop,
  output bru_pkg::item_t     head,
  output bru_pkg::q_status_t status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bru_pkg::item_t q_mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  cnt, cnt_next;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) cnt_next = cnt + CW'(1);
    else if (pop && !push) cnt_next = cnt - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      cnt <= cnt_next;
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= push_item;
  end

  assign head         = q_mem[rd_ptr];
  assign status.empty = (cnt == '0);
  assign status.full  = (cnt == CW'(DEPTH));

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push && !pop, !status.full, "queue push while full")
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !status.empty, "queue pop while empty")

endmodule

/* hdl/bru_back.sv */
`include "assert_macros.svh"

module bru_back #(
  parameter int SRC_WIDTH  = bru_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = bru_pkg::SRC_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bru_pkg::q_status_t         q_stat,
  input  bru_pkg::item_t             head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bru_pkg::RGB_W-1:0]  out_data
);

  localparam int PW  = bru_pkg::POS_W;
  localparam int FW  = bru_pkg::FRAC_W;
  localparam int CHW = bru_pkg::CH_W;
  localparam int HW  = (SRC_WIDTH + 1) / 2;
  localparam int HH  = (SRC_HEIGHT + 1) / 2;
  localparam int BD  = HW * HH;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

  localparam logic [BAW-1:0] HW_C    = BAW'(HW);
  localparam logic [PW:0]    SRC_W_C = (PW + 1)'(SRC_WIDTH);
  localparam logic [PW:0]    SRC_H_C = (PW + 1)'(SRC_HEIGHT);

  function automatic logic signed [17:0] diff_mul(input logic [CHW-1:0] a,
                                                 input logic [CHW-1:0] b,
                                                 input logic [FW-1:0] f);
    logic signed [8:0] d;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    return d * $signed({1'b0, f});
  endfunction

  // a + floor(p / 256)
  function automatic logic [CHW-1:0] lerp_fin(input logic [CHW-1:0] a,
                                             input logic signed [17:0] p);
    logic signed [17:0] sh;
    logic [9:0]         s;
    sh = p >>> FW;
    s  = {2'b00, a} + sh[9:0];
    return s[CHW-1:0];
  endfunction

  logic en;
  assign en  = !out_valid || out_ready;
  assign pop = en && !q_stat.empty;

  // stage 0: item off the queue
  logic           b0_v;
  bru_pkg::item_t b0_it;

  always_ff @(posedge clk) begin
    if (rst) b0_v <= 1'b0;
    else if (en) b0_v <= !q_stat.empty;
    if (en) b0_it <= head;
  end

  logic [PW-1:0]  x1, y1, xe, xo, ye, yo;
  logic [BAW-1:0] addr [4];
  logic [3:0]     we;

  always_comb begin
    x1 = (({1'b0, b0_it.x} + (PW + 1)'(1)) < SRC_W_C) ? b0_it.x + PW'(1) : b0_it.x;
    y1 = (({1'b0, b0_it.y} + (PW + 1)'(1)) < SRC_H_C) ? b0_it.y + PW'(1) : b0_it.y;
    xe = b0_it.x[0] ? x1 : b0_it.x;
    xo = b0_it.x[0] ? b0_it.x : x1;
    ye = b0_it.y[0] ? y1 : b0_it.y;
    yo = b0_it.y[0] ? b0_it.y : y1;
    // bank index is {row parity, column parity}
    addr[0] = BAW'(ye[PW-1:1]) * HW_C + BAW'(xe[PW-1:1]);
    addr[1] = BAW'(ye[PW-1:1]) * HW_C + BAW'(xo[PW-1:1]);
    addr[2] = BAW'(yo[PW-1:1]) * HW_C + BAW'(xe[PW-1:1]);
    addr[3] = BAW'(yo[PW-1:1]) * HW_C + BAW'(xo[PW-1:1]);
    we = '0;
    if (b0_v && b0_it.kind == bru_pkg::KIND_LOAD) we[{b0_it.y[0], b0_it.x[0]}] = 1'b1;
  end

  logic [bru_pkg::RGB_W-1:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [bru_pkg::RGB_W-1:0] mem [BD];
    always_ff @(posedge clk) begin
      if (en) begin
        if (we[b]) mem[addr[b]] <= b0_it.rgb;
        rd[b] <= mem[addr[b]];
      end
    end
  end

  // stage 1: bank data ready
  logic          b1_v, b1_req, b1_x0p, b1_x1p, b1_y0p, b1_y1p;
  logic [FW-1:0] b1_fx, b1_fy;

  always_ff @(posedge clk) begin
    if (rst) b1_v <= 1'b0;
    else if (en) b1_v <= b0_v;
    if (en) begin
      b1_req <= (b0_it.kind == bru_pkg::KIND_REQ);
      b1_fx  <= b0_it.fx;
      b1_fy  <= b0_it.fy;
      b1_x0p <= b0_it.x[0];
      b1_x1p <= x1[0];
      b1_y0p <= b0_it.y[0];
      b1_y1p <= y1[0];
    end
  end

  logic [bru_pkg::RGB_W-1:0] p00, p01, p10, p11;
  logic signed [17:0]        tp_c [3];
  logic signed [17:0]        bp_c [3];

  always_comb begin
    p00 = rd[{b1_y0p, b1_x0p}];
    p01 = rd[{b1_y0p, b1_x1p}];
    p10 = rd[{b1_y1p, b1_x0p}];
    p11 = rd[{b1_y1p, b1_x1p}];
    for (int c = 0; c < 3; c++) begin
      tp_c[c] = diff_mul(p00[CHW*c +: CHW], p01[CHW*c +: CHW], b1_fx);
      bp_c[c] = diff_mul(p10[CHW*c +: CHW], p11[CHW*c +: CHW], b1_fx);
    end
  end

  // stage 2: horizontal products; channel c sits at bits 8c (blue at c = 0)
  logic               b2_v;
  logic [FW-1:0]      b2_fy;
  logic [CHW-1:0]     b2_ta [3];
  logic [CHW-1:0]     b2_ba [3];
  logic signed [17:0] b2_tp [3];
  logic signed [17:0] b2_bp [3];

  always_ff @(posedge clk) begin
    if (rst) b2_v <= 1'b0;
    else if (en) b2_v <= b1_v && b1_req;
    if (en) begin
      b2_fy <= b1_fy;
      for (int c = 0; c < 3; c++) begin
        b2_ta[c] <= p00[CHW*c +: CHW];
        b2_ba[c] <= p10[CHW*c +: CHW];
        b2_tp[c] <= tp_c[c];
        b2_bp[c] <= bp_c[c];
      end
    end
  end

  logic [CHW-1:0]     top_c [3];
  logic signed [17:0] vp_c  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      top_c[c] = lerp_fin(b2_ta[c], b2_tp[c]);
      vp_c[c]  = diff_mul(top_c[c], lerp_fin(b2_ba[c], b2_bp[c]), b2_fy);
    end
  end

  // stage 3: vertical products
  logic               b3_v;
  logic [CHW-1:0]     b3_a [3];
  logic signed [17:0] b3_p [3];

  always_ff @(posedge clk) begin
    if (rst) b3_v <= 1'b0;
    else if (en) b3_v <= b2_v;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        b3_a[c] <= top_c[c];
        b3_p[c] <= vp_c[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= b3_v;
    if (en) begin
      // red in the low byte, blue in the high byte
      out_data[CHW-1:0]       <= lerp_fin(b3_a[2], b3_p[2]);
      out_data[2*CHW-1:CHW]   <= lerp_fin(b3_a[1], b3_p[1]);
      out_data[3*CHW-1:2*CHW] <= lerp_fin(b3_a[0], b3_p[0]);
    end
  end

  `ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && !out_ready, $stable(b3_v) && $stable(b1_v), "pipeline moved while output stalled")

endmodule

/* hdl/bilinear_rgb_upscaler.sv */
// Bilinear RGB upscaler.
// s_axis carries one item per transfer: tuser = command (0 load, 1 request),
// tdata = pos_x, pos_y, red, green, blue. A load writes one pixel of the
// SRC_WIDTH x SRC_HEIGHT source image held in four on-chip banks; a load
// outside the source is dropped. A request names an output pixel of an
// out_width x out_height image and yields one m_axis transfer with the
// interpolated red, green and blue bytes; loads yield nothing.
// The cfg channel writes out_width (index 0) and out_height (index 1); write
// it only while no item is in flight. cfg_ready is always high.
// Throughput: one item per clock while s_axis_tready is high. Each axis
// maps through a pipelined restoring divider of
// Q = max(clog2(SRC_WIDTH), clog2(SRC_HEIGHT)) + 8 stages.
// A 32-entry queue separates mapping from the memory and blend pipeline;
// s_axis_tready drops once 32 items are in flight, so a stalled m_axis
// fills the queue and then holds off the source. Results are held stable
// until taken.
// Reset clears the pipeline and queue and restores 640 x 480; the source
// image keeps its contents and must be loaded before it is read.
`include "assert_macros.svh"

module bilinear_rgb_upscaler #(
  parameter int SRC_WIDTH   = bru_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT  = bru_pkg::SRC_HEIGHT_DEF,
  parameter int MAX_OUT_DIM = bru_pkg::MAX_OUT_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [47:0]                        s_axis_tdata,  // pos_x, pos_y, red, green, blue
  input  logic                               s_axis_tuser,  // command
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bru_pkg::RGB_W-1:0]          m_axis_tdata,  // red_out, green_out, blue_out
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bru_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bru_pkg::CFG_W-1:0]          cfg_data
);

  localparam int OCW = $clog2(bru_pkg::QDEPTH + 1);
  localparam int PW  = bru_pkg::POS_W;
  localparam int CHW = bru_pkg::CH_W;

  logic [bru_pkg::CFG_W-1:0] out_width, out_height;
  logic [OCW-1:0]            occ, occ_next;
  logic                      in_take, push, pop;
  bru_pkg::item_t            push_item, head;
  bru_pkg::q_status_t        q_stat;
  logic [bru_pkg::RGB_W-1:0] in_rgb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= bru_pkg::OUT_WIDTH_RST;
      out_height <= bru_pkg::OUT_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        bru_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data;
        bru_pkg::REG_OUT_HEIGHT: out_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // count items between acceptance and queue pop; cap it at the queue depth
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (occ < OCW'(bru_pkg::QDEPTH));

  always_comb begin
    occ_next = occ;
    if (in_take && !pop) occ_next = occ + OCW'(1);
    else if (pop && !in_take) occ_next = occ - OCW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) occ <= '0;
    else occ <= occ_next;
  end

  assign in_rgb = {s_axis_tdata[2*PW +: CHW], s_axis_tdata[2*PW+CHW +: CHW],
                   s_axis_tdata[2*PW+2*CHW +: CHW]};

  bru_front #(
    .SRC_WIDTH(SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT),
    .MAX_OUT_DIM(MAX_OUT_DIM)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_take(in_take),
    .in_cmd(s_axis_tuser),
    .in_x(s_axis_tdata[PW-1:0]),
    .in_y(s_axis_tdata[2*PW-1:PW]),
    .in_rgb(in_rgb),
    .out_width(out_width),
    .out_height(out_height),
    .push(push),
    .push_item(push_item)
  );

  bru_fifo #(
    .DEPTH(bru_pkg::QDEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .pop(pop),
    .head(head),
    .status(q_stat)
  );

  bru_back #(
    .SRC_WIDTH(SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_stat(q_stat),
    .head(head),
    .pop(pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data(m_axis_tdata)
  );

  `ASSERT_ALWAYS(a_credit_bound, clk, rst, occ <= OCW'(bru_pkg::QDEPTH), "in-flight count above queue depth")

endmodule

/* tb/tb_bilinear_rgb_upscaler.sv */
`timescale 1ns / 1ps

module tb_bilinear_rgb_upscaler;

  localparam int SRC_W      = bru_pkg::SRC_WIDTH_DEF;
  localparam int SRC_H      = bru_pkg::SRC_HEIGHT_DEF;
  localparam int PW         = bru_pkg::POS_W;
  localparam int CW         = bru_pkg::CH_W;
  localparam int FW         = bru_pkg::FRAC_W;
  localparam int RW         = bru_pkg::RGB_W;
  localparam int DW         = bru_pkg::CFG_W;
  localparam int AW         = bru_pkg::CFG_ADDR_W;
  localparam int MAX_DIM    = bru_pkg::MAX_OUT_DIM_DEF;
  localparam int DRAIN_CYC  = 40;
  localparam int LIMIT_CYC  = 600000;
  localparam int LONG_STALL = 400;

  typedef struct {
    logic          cmd;
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
  } pix_req_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [RW-1:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [AW-1:0] cfg_addr;
  logic [DW-1:0] cfg_data;

  bilinear_rgb_upscaler DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // scoreboard state
  logic [RW-1:0] src_image [0:SRC_W*SRC_H-1];
  bit            loaded [0:SRC_W*SRC_H-1];
  logic [DW-1:0] width_reg;
  logic [DW-1:0] height_reg;
  logic [RW-1:0] pixel_expected [$];
  pix_req_t      pending_reqs [$];
  pix_req_t      on_bus;

  int  snd_idle_pct;
  int  rcv_idle_pct;
  int  rcv_stall_left = 0;
  bit  stall_req = 1'b0;
  bit  stall_taken = 1'b0;
  int  mismatches = 0;
  int  unexpected = 0;
  int  results_seen = 0;
  int  loads_sent;
  int  reqs_sent;
  int  cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_dim(logic [DW-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // source position with 8 fraction bits
  function automatic longint map_pos(int pos, int dim, int src_size);
    longint divisor;
    divisor = longint'((dim > 1) ? dim - 1 : 1);
    if (pos >= dim) pos = dim - 1;
    return ((longint'(pos) * longint'(src_size - 1)) << FW) / divisor;
  endfunction

  function automatic void src_corners(input int px, input int py,
                                      output int x0, output int x1, output int y0,
                                      output int y1, output int fx, output int fy);
    longint sx, sy;
    sx = map_pos(px, eff_dim(width_reg), SRC_W);
    sy = map_pos(py, eff_dim(height_reg), SRC_H);
    x0 = int'(sx >> FW);
    fx = int'(sx & 255);
    y0 = int'(sy >> FW);
    fy = int'(sy & 255);
    if (x0 > SRC_W - 1) x0 = SRC_W - 1;
    if (y0 > SRC_H - 1) y0 = SRC_H - 1;
    x1 = (x0 + 1 < SRC_W) ? x0 + 1 : SRC_W - 1;
    y1 = (y0 + 1 < SRC_H) ? y0 + 1 : SRC_H - 1;
  endfunction

  // a + floor((b - a) * f / 256)
  function automatic int blend(int a, int b, int f);
    int p;
    p = (b - a) * f;
    return a + (p >>> FW);
  endfunction

  function automatic logic [RW-1:0] interp_pixel(int px, int py);
    int x0, x1, y0, y1, fx, fy, sh, top, bot;
    logic [RW-1:0] p00, p01, p10, p11, res;
    src_corners(px, py, x0, x1, y0, y1, fx, fy);
    p00 = src_image[y0*SRC_W + x0];
    p01 = src_image[y0*SRC_W + x1];
    p10 = src_image[y1*SRC_W + x0];
    p11 = src_image[y1*SRC_W + x1];
    res = '0;
    for (int c = 0; c < 3; c++) begin
      sh = 16 - 8*c;
      top = blend(int'((p00 >> sh) & 8'hFF), int'((p01 >> sh) & 8'hFF), fx);
      bot = blend(int'((p10 >> sh) & 8'hFF), int'((p11 >> sh) & 8'hFF), fx);
      // result packs red in the low byte
      res[8*c +: 8] = 8'(blend(top, bot, fy));
    end
    return res;
  endfunction

  function automatic void predict_item(pix_req_t it);
    if (it.cmd == bru_pkg::CMD_LOAD) begin
      if (it.x < SRC_W && it.y < SRC_H)
        src_image[it.y*SRC_W + it.x] = {it.r, it.g, it.b};
    end else begin
      pixel_expected.push_back(interp_pixel(int'(it.x), int'(it.y)));
    end
  endfunction

  task automatic add_load(int x, int y, int r, int g, int b);
    pix_req_t it;
    it.cmd = bru_pkg::CMD_LOAD;
    it.x = PW'(x); it.y = PW'(y); it.r = CW'(r); it.g = CW'(g); it.b = CW'(b);
    if (x < SRC_W && y < SRC_H) loaded[y*SRC_W + x] = 1'b1;
    pending_reqs.push_back(it);
    loads_sent++;
  endtask

  // load any corner not yet written, then the request itself
  task automatic add_request(int x, int y);
    pix_req_t it;
    int x0, x1, y0, y1, fx, fy;
    int cx [4];
    int cy [4];
    src_corners(x, y, x0, x1, y0, y1, fx, fy);
    cx = '{x0, x1, x0, x1};
    cy = '{y0, y0, y1, y1};
    for (int k = 0; k < 4; k++)
      if (!loaded[cy[k]*SRC_W + cx[k]])
        add_load(cx[k], cy[k], $urandom_range(255), $urandom_range(255), $urandom_range(255));
    it.cmd = bru_pkg::CMD_REQUEST;
    it.x = PW'(x); it.y = PW'(y);
    it.r = CW'($urandom_range(255));
    it.g = CW'($urandom_range(255));
    it.b = CW'($urandom_range(255));
    pending_reqs.push_back(it);
    reqs_sent++;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || pixel_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_reg(logic [AW-1:0] addr, logic [DW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (addr == bru_pkg::REG_OUT_WIDTH) width_reg = val;
    else if (addr == bru_pkg::REG_OUT_HEIGHT) height_reg = val;
  endtask

  task automatic random_items(int n);
    int wmax, hmax;
    for (int i = 0; i < n; i++) begin
      wmax = eff_dim(width_reg);
      hmax = eff_dim(height_reg);
      case ($urandom_range(9))
        0, 1: add_load($urandom_range(SRC_W-1), $urandom_range(SRC_H-1),
                       $urandom_range(255), $urandom_range(255), $urandom_range(255));
        2: add_load($urandom_range(4095), $urandom_range(4095),
                    $urandom_range(255), $urandom_range(255), $urandom_range(255));
        3: add_request($urandom_range(4095), $urandom_range(4095));
        default: add_request($urandom_range(wmax-1), $urandom_range(hmax-1));
      endcase
    end
  endtask

  // sender: present queued items, idle at random
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_item(on_bus);
      if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        on_bus = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= on_bus.cmd;
        s_axis_tdata  <= {on_bus.b, on_bus.g, on_bus.r, on_bus.y, on_bus.x};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: check results, stall at random or for a long hold-off
  always @(posedge clk) begin
    logic [RW-1:0] exp_px;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pixel_expected.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("unexpected result %h at %0t", m_axis_tdata, $time);
        end else begin
          exp_px = pixel_expected.pop_front();
          if (exp_px !== m_axis_tdata) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("mismatch at %0t: red exp %h got %h, green exp %h got %h, blue exp %h got %h",
                       $time, exp_px[7:0], m_axis_tdata[7:0], exp_px[15:8],
                       m_axis_tdata[15:8], exp_px[23:16], m_axis_tdata[23:16]);
          end
        end
      end
      if (stall_req && !stall_taken) begin
        stall_taken    <= 1'b1;
        rcv_stall_left <= LONG_STALL;
        m_axis_tready  <= 1'b0;
      end else if (rcv_stall_left > 0) begin
        rcv_stall_left <= rcv_stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_bilinear_rgb_upscaler: FAIL");
      $finish;
    end
  end

  initial begin
    logic [DW-1:0] widths [9];
    logic [DW-1:0] heights [9];
    int leftover;
    widths  = '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd2, 13'd320, 13'd17, 13'd1000, 13'd640};
    heights = '{13'd1, 13'd0, 13'd4096, 13'd8191, 13'd2, 13'd240, 13'd3, 13'd700, 13'd480};
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    width_reg = bru_pkg::OUT_WIDTH_RST;
    height_reg = bru_pkg::OUT_HEIGHT_RST;
    snd_idle_pct = 36;
    rcv_idle_pct = 57;
    loads_sent = 0; reqs_sent = 0;
    for (int i = 0; i < SRC_W*SRC_H; i++) loaded[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset size, extremes, dropped loads, clamped requests
    add_load(0, 0, 8'h00, 8'hFF, 8'h00);
    add_load(1, 0, 8'hFF, 8'h00, 8'hFF);
    add_load(0, 1, 8'hFF, 8'hFF, 8'h00);
    add_load(1, 1, 8'h00, 8'h00, 8'hFF);
    add_load(SRC_W-1, SRC_H-1, 8'hFF, 8'hFF, 8'hFF);
    add_load(SRC_W, 0, 8'h12, 8'h34, 8'h56);
    add_load(0, SRC_H, 8'h12, 8'h34, 8'h56);
    add_load(4095, 4095, 8'hFF, 8'hFF, 8'hFF);
    add_request(0, 0);
    add_request(1, 1);
    add_request(2, 3);
    add_request(639, 479);
    add_request(640, 480);
    add_request(4095, 4095);
    add_request(4095, 0);
    add_request(0, 4095);
    add_request(320, 240);
    add_request(2730, 1365);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      write_reg(bru_pkg::REG_OUT_WIDTH, widths[ph]);
      write_reg(bru_pkg::REG_OUT_HEIGHT, heights[ph]);
      if (ph == 3) begin
        snd_idle_pct = 57; rcv_idle_pct = 36;
      end else if (ph == 6) begin
        snd_idle_pct = 0; rcv_idle_pct = 0;
        stall_req = 1'b1;
      end
      random_items(56);
      wait_drained();
    end

    leftover = pixel_expected.size();
    $display("covered %0d loads and %0d requests over 10 output sizes, %0d results checked",
             loads_sent, reqs_sent, results_seen);
    $display("sizes 0 to 8191 incl. clamping, out-of-range loads and requests, long stall");
    if (mismatches == 0 && unexpected == 0 && leftover == 0) begin
      $display("tb_bilinear_rgb_upscaler: PASS");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", mismatches, unexpected, leftover);
      $display("tb_bilinear_rgb_upscaler: FAIL");
    end
    $finish;
  end

endmodule
